### hw/rtl/gpp_pkg.sv
// Shared widths, register codes and word types for the grid point placement block.
package gpp_pkg;

  localparam int IDX_W      = 16;  // particle index, row and column
  localparam int DIV_STEPS  = IDX_W;
  localparam int Q_W        = 16;  // Q8.8 and Q2.14 lanes
  localparam int CFG_W      = 48;  // three packed lanes
  localparam int CFG_IDX_W  = 3;
  localparam int GRID_W     = 2 * IDX_W;  // col or row times spacing
  localparam int PROD_W     = GRID_W + Q_W + 1;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC       = 14;  // Q.22 to Q8.8
  localparam int ROUND_BIAS = 8192;
  localparam int RES_W      = ACC_W - FRAC;
  localparam int INDEX_LIMIT = 65536;
  localparam int LIM_W      = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_U  = 3'd0,
    CFG_AXIS_V  = 3'd1,
    CFG_ORIGIN  = 3'd2,
    CFG_SPACING = 3'd3,
    CFG_COLUMNS = 3'd4,
    CFG_ROWS    = 3'd5
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] AXIS_U_RST  = 48'h0000_0000_4000;
  localparam logic [CFG_W-1:0] AXIS_V_RST  = 48'h4000_0000_0000;
  localparam logic [Q_W-1:0]   SPACING_RST = 16'd256;
  localparam logic [IDX_W-1:0] COLUMNS_RST = 16'd16;
  localparam logic [IDX_W-1:0] ROWS_RST    = 16'd16;

  // divider tail word
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] quot;
    logic [IDX_W-1:0] rem;
  } div_res_t;

  // one world component after rounding
  typedef struct packed {
    logic signed [Q_W-1:0] pos;
    logic                  clip;
  } lane_res_t;

endpackage

### hw/rtl/gpp_divider.sv
// Pipelined restoring divider: one quotient bit per register stage.
module gpp_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic                      tag,
  input  logic [gpp_pkg::IDX_W-1:0] dividend,
  input  logic [gpp_pkg::IDX_W-1:0] divisor,
  output gpp_pkg::div_res_t         res
);
  import gpp_pkg::*;

  logic             v_r   [DIV_STEPS];
  logic             tag_r [DIV_STEPS];
  logic [IDX_W-1:0] idx_r [DIV_STEPS];
  logic [IDX_W-1:0] rem_r [DIV_STEPS];
  logic [IDX_W-1:0] q_r   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic             v_in;
    logic             tag_in;
    logic [IDX_W-1:0] idx_in;
    logic [IDX_W-1:0] rem_in;
    logic [IDX_W-1:0] q_in;
    logic [IDX_W:0]   trial;
    logic [IDX_W:0]   diff;
    logic             ge;
    logic [IDX_W-1:0] rem_nxt;
    logic [IDX_W-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_v;
      assign tag_in = tag;
      assign idx_in = dividend;
      assign rem_in = '0;
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign tag_in = tag_r[k-1];
      assign idx_in = idx_r[k-1];
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
    end

    // partial remainder stays below the divisor, so the difference fits
    assign trial   = {rem_in, idx_in[IDX_W-1-k]};
    assign diff    = trial - {1'b0, divisor};
    assign ge      = (trial >= {1'b0, divisor});
    assign rem_nxt = ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
    assign q_nxt   = {q_in[IDX_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_in;
        idx_r[k] <= idx_in;
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign res.valid = v_r[DIV_STEPS-1];
  assign res.last  = tag_r[DIV_STEPS-1];
  assign res.idx   = idx_r[DIV_STEPS-1];
  assign res.quot  = q_r[DIV_STEPS-1];
  assign res.rem   = rem_r[DIV_STEPS-1];

endmodule

### hw/rtl/gpp_axis_lane.sv
// One world component: two products, sum with origin, round and saturate.
module gpp_axis_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic        [gpp_pkg::GRID_W-1:0] gx,
  input  logic        [gpp_pkg::GRID_W-1:0] gz,
  input  logic signed [gpp_pkg::Q_W-1:0]    u,
  input  logic signed [gpp_pkg::Q_W-1:0]    v,
  input  logic signed [gpp_pkg::Q_W-1:0]    o,
  output gpp_pkg::lane_res_t                res
);
  import gpp_pkg::*;

  logic signed [PROD_W-1:0] pu_r, pv_r;
  logic signed [ACC_W-1:0]  acc_nxt, acc_r;
  logic signed [ACC_W-1:0]  org_q22;
  logic signed [RES_W-1:0]  rnd;
  logic                     hi, lo;
  lane_res_t                res_nxt, res_r;

  assign org_q22 = {{(ACC_W-Q_W-FRAC){o[Q_W-1]}}, o, {FRAC{1'b0}}};
  assign acc_nxt = ACC_W'(pu_r) + ACC_W'(pv_r) + org_q22 + ACC_W'(ROUND_BIAS);

  // floor shift: round half up after the bias
  assign rnd = acc_r[ACC_W-1:FRAC];
  assign hi  = (rnd > RES_W'(32767));
  assign lo  = (rnd < -RES_W'(32768));

  always_comb begin
    res_nxt.clip = hi | lo;
    if (hi) begin
      res_nxt.pos = 16'sh7FFF;
    end else if (lo) begin
      res_nxt.pos = -16'sh8000;
    end else begin
      res_nxt.pos = rnd[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r  <= $signed({1'b0, gx}) * u;
      pv_r  <= $signed({1'b0, gz}) * v;
      acc_r <= acc_nxt;
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### hw/rtl/grid_point_placement.sv
// Top level of the grid point placement block: config, divider, scaling, lanes, output.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | particle_index, last_in_range
//  out_    | output    | out_valid/out_stall| point_index, pos_x/y/z, in_grid, saturated, last_out
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (ready always high)
//
// One word per cycle sustained while in_stall is low; the path runs through 16 divider steps,
// one scaling multiply stage, three lane stages and the output register.
// The whole datapath moves on a single enable, which is the skid register being empty.
// A word caught while the output is stalled lands in the skid register; in_stall is
// that register's full flag, so it rises the cycle after a stalled output word has
// another word arriving behind it.
// rst_n is synchronous: valids clear and config registers return to defaults.
module grid_point_placement #(
  parameter int INDEX_LIMIT = gpp_pkg::INDEX_LIMIT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gpp_pkg::IDX_W-1:0]    in_particle_index,
  input  logic                         in_last_in_range,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gpp_pkg::IDX_W-1:0]    out_point_index,
  output logic signed [gpp_pkg::Q_W-1:0] out_pos_x,
  output logic signed [gpp_pkg::Q_W-1:0] out_pos_y,
  output logic signed [gpp_pkg::Q_W-1:0] out_pos_z,
  output logic                         out_in_grid,
  output logic                         out_saturated,
  output logic                         out_last_out,
  // config writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gpp_pkg::CFG_W-1:0]    cfg_data
);
  import gpp_pkg::*;

  typedef struct packed {
    logic             valid;
    logic             in_grid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } meta_t;

  typedef struct packed {
    logic [IDX_W-1:0]      idx;
    logic signed [Q_W-1:0] px;
    logic signed [Q_W-1:0] py;
    logic signed [Q_W-1:0] pz;
    logic                  in_grid;
    logic                  sat;
    logic                  last;
  } out_word_t;

  localparam int LANE_STAGES = 3;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] axis_u_r, axis_v_r, origin_r;
  logic [Q_W-1:0]   spacing_r;
  logic [IDX_W-1:0] columns_r, rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_u_r  <= AXIS_U_RST;
      axis_v_r  <= AXIS_V_RST;
      origin_r  <= '0;
      spacing_r <= SPACING_RST;
      columns_r <= COLUMNS_RST;
      rows_r    <= ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_AXIS_U:  axis_u_r  <= cfg_data;
        CFG_AXIS_V:  axis_v_r  <= cfg_data;
        CFG_ORIGIN:  origin_r  <= cfg_data;
        CFG_SPACING: spacing_r <= cfg_data[Q_W-1:0];
        CFG_COLUMNS: columns_r <= cfg_data[IDX_W-1:0];
        CFG_ROWS:    rows_r    <= cfg_data[IDX_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic skid_v_r;
  logic en;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // ---------------------------------------------------------------- row / column
  logic [IDX_W-1:0] divisor;
  div_res_t         dres;

  // zero columns behaves as one column
  assign divisor = (columns_r == '0) ? IDX_W'(1) : columns_r;

  gpp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_valid),
    .tag      (in_last_in_range),
    .dividend (in_particle_index),
    .divisor  (divisor),
    .res      (dres)
  );

  // ---------------------------------------------------------------- scaling
  meta_t             s_r, s_nxt;
  logic [GRID_W-1:0] gx_r, gz_r;

  always_comb begin
    s_nxt.valid   = dres.valid;
    s_nxt.last    = dres.last;
    s_nxt.idx     = dres.idx;
    s_nxt.in_grid = (dres.quot < rows_r) &&
                    ({{(LIM_W-IDX_W){1'b0}}, dres.idx} < LIM_W'(INDEX_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (en) begin
      s_r.valid <= s_nxt.valid;
    end
    if (en) begin
      s_r.in_grid <= s_nxt.in_grid;
      s_r.last    <= s_nxt.last;
      s_r.idx     <= s_nxt.idx;
      gx_r        <= dres.rem * spacing_r;
      gz_r        <= dres.quot * spacing_r;
    end
  end

  // ---------------------------------------------------------------- lanes
  lane_res_t lres [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    gpp_axis_lane u_lane (
      .clk (clk),
      .en  (en),
      .gx  (gx_r),
      .gz  (gz_r),
      .u   (axis_u_r[Q_W*k +: Q_W]),
      .v   (axis_v_r[Q_W*k +: Q_W]),
      .o   (origin_r[Q_W*k +: Q_W]),
      .res (lres[k])
    );
  end

  // sideband follows the lane stages
  meta_t m_r [LANE_STAGES];

  for (genvar k = 0; k < LANE_STAGES; k++) begin : g_meta
    meta_t m_in;
    if (k == 0) begin : g_first
      assign m_in = s_r;
    end else begin : g_next
      assign m_in = m_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m_r[k].valid <= 1'b0;
      end else if (en) begin
        m_r[k].valid <= m_in.valid;
      end
      if (en) begin
        m_r[k].in_grid <= m_in.in_grid;
        m_r[k].last    <= m_in.last;
        m_r[k].idx     <= m_in.idx;
      end
    end
  end

  // ---------------------------------------------------------------- output
  meta_t     tail;
  out_word_t tail_word;
  out_word_t out_r, skid_r;
  logic      out_v_r;

  assign tail = m_r[LANE_STAGES-1];

  // points outside the grid report zero position and no clipping
  always_comb begin
    tail_word.idx     = tail.idx;
    tail_word.in_grid = tail.in_grid;
    tail_word.last    = tail.last;
    tail_word.px      = tail.in_grid ? lres[0].pos : '0;
    tail_word.py      = tail.in_grid ? lres[1].pos : '0;
    tail_word.pz      = tail.in_grid ? lres[2].pos : '0;
    tail_word.sat     = tail.in_grid & (lres[0].clip | lres[1].clip | lres[2].clip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && out_stall) begin
      if (en && tail.valid) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= en && tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && out_stall) begin
      if (en && tail.valid) begin
        skid_r <= tail_word;
      end
    end else if (skid_v_r) begin
      out_r <= skid_r;
    end else begin
      out_r <= tail_word;
    end
  end

  assign out_valid       = out_v_r;
  assign out_point_index = out_r.idx;
  assign out_pos_x       = out_r.px;
  assign out_pos_y       = out_r.py;
  assign out_pos_z       = out_r.pz;
  assign out_in_grid     = out_r.in_grid;
  assign out_saturated   = out_r.sat;
  assign out_last_out    = out_r.last;

`ifndef SYNTHESIS
  // skid only holds a word while the output register is occupied
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid)
    else $error("skid word held with empty output register");

  // an unplaced point carries no position and no clip flag
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_grid) |->
      (out_pos_x == '0 && out_pos_y == '0 && out_pos_z == '0 && !out_saturated))
    else $error("outside point carries position data");

  // input backpressure only follows a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall raised without output stall");
`endif

endmodule
